>>> rtl/bfscs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bfscs_pkg;

  localparam int FLAG_COUNT = 255;
  localparam int WORD_BITS  = 64;
  localparam int WORD_TOTAL = (FLAG_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW    = (WORD_TOTAL > 1) ? $clog2(WORD_TOTAL) : 1;
  localparam int WCNT_W     = $clog2(WORD_TOTAL + 1);
  localparam int ID_W       = 8;
  localparam int REQ_W      = 3;

  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd0;
  localparam logic [REQ_W-1:0] REQ_MARK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TEST  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_NEXT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PREV  = 3'd4;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [ID_W-1:0]  item_id;
  } req_t;

  typedef struct packed {
    logic            is_set;
    logic [ID_W-1:0] found_id;
    logic [ID_W-1:0] total_set;
  } rsp_t;

  // Per-word scan results. The primary candidate is the one that wins over
  // the wrapped candidate: lowest id above the start for an upward search,
  // highest id below the start for a downward search.
  typedef struct packed {
    logic            hit_a;
    logic [ID_W-1:0] id_a;
    logic            hit_b;
    logic [ID_W-1:0] id_b;
    logic            sel_hit;
    logic            sel_in;
  } scan_t;

endpackage

`default_nettype wire

>>> rtl/bfscs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bfscs_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 4,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [AW-1:0]       wr_addr,
  input  wire logic [WIDTH-1:0]    wr_data,
  input  wire logic                rd_en,
  input  wire logic [AW-1:0]       rd_addr,
  output logic      [WIDTH-1:0]    rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/bfscs_word_scan.sv
`timescale 1ns / 1ps
`default_nettype none

module bfscs_word_scan (
  input  wire logic [bfscs_pkg::WORD_BITS-1:0] word,
  input  wire logic [bfscs_pkg::ID_W-1:0]      base_id,
  input  wire logic [bfscs_pkg::ID_W-1:0]      item_id,
  input  wire logic                            down,
  output bfscs_pkg::scan_t                     res,
  output logic      [bfscs_pkg::WORD_BITS-1:0] marked
);

  localparam int W  = bfscs_pkg::WORD_BITS;
  localparam int IW = bfscs_pkg::ID_W;

  logic [W-1:0] cand_a;
  logic [W-1:0] cand_b;
  logic [W-1:0] match;

  always_comb begin
    logic [IW:0] bid;
    logic        in_rng;
    logic        above;
    logic        below;
    for (int i = 0; i < W; i++) begin
      bid       = {1'b0, base_id} + (IW + 1)'(i);
      in_rng    = bid <= (IW + 1)'(bfscs_pkg::FLAG_COUNT);
      above     = bid > {1'b0, item_id};
      below     = bid < {1'b0, item_id};
      match[i]  = in_rng && (bid == {1'b0, item_id});
      cand_a[i] = word[i] && in_rng && (down ? below : above);
      cand_b[i] = word[i] && in_rng && (down ? above : 1'b1);
    end
  end

  // The later hit in the loop wins, so the walk direction picks the lowest
  // bit for an upward search and the highest bit for a downward one.
  always_comb begin
    int k;
    res = '0;
    for (int j = 0; j < W; j++) begin
      k = down ? j : (W - 1 - j);
      if (cand_a[k]) begin
        res.hit_a = 1'b1;
        res.id_a  = IW'({1'b0, base_id} + (IW + 1)'(k));
      end
      if (cand_b[k]) begin
        res.hit_b = 1'b1;
        res.id_b  = IW'({1'b0, base_id} + (IW + 1)'(k));
      end
    end
    res.sel_hit = |(word & match);
    res.sel_in  = |match;
  end

  assign marked = word | match;

endmodule

`default_nettype wire

>>> rtl/bitmap_flag_set_circular_search_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Flag bitmap with circular search.
// Requests arrive on the req channel (req_valid / req_stall, payload req)
// and each produces exactly one response on the rsp channel (rsp_valid /
// rsp_stall, payload rsp). A transaction completes at a clock edge where
// valid is high and stall is low.
// The bitmap lives in a single-port-write, registered-read word RAM. Every
// request other than clear walks all bitmap words in order, one RAM read per
// cycle; marks write the updated word back in the cycle its data returns.
// A clear request goes from IDLE straight to FINISH; every other request
// passes through SCAN over all WORD_TOTAL words before FINISH.
// One request is in flight at a time: req_stall is high from acceptance
// until the response is loaded into the output register.
// A finished response waits in the output register while rsp_stall is high;
// the next request can be accepted while it waits, but its own response is
// held back until the register is free.
// Reset (rst, synchronous) empties the bitmap through per-word valid bits
// and zeroes the count; no clearing pass is needed.

module bitmap_flag_set_circular_search_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_stall,
  input  wire bfscs_pkg::req_t req,
  output logic                 rsp_valid,
  input  wire logic            rsp_stall,
  output bfscs_pkg::rsp_t      rsp
);

  localparam int W   = bfscs_pkg::WORD_BITS;
  localparam int IW  = bfscs_pkg::ID_W;
  localparam int AW  = bfscs_pkg::WORD_AW;
  localparam int CW  = bfscs_pkg::WCNT_W;
  localparam int WT  = bfscs_pkg::WORD_TOTAL;

  typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_t;

  state_t             state;
  bfscs_pkg::req_t    cur;
  logic [CW-1:0]      iss;
  logic [AW-1:0]      proc_idx;
  logic               rd_pending;
  logic               rd_valid;
  logic [IW-1:0]      base_id;
  logic               have_a;
  logic [IW-1:0]      id_a;
  logic               have_b;
  logic [IW-1:0]      id_b;
  logic               hit_any;
  logic [IW-1:0]      set_count;
  logic [WT-1:0]      word_valid;

  logic               req_acc;
  logic               is_clear;
  logic               is_down;
  logic               is_search;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [W-1:0]       rd_data;
  logic [W-1:0]       eff_word;
  logic [W-1:0]       marked;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               mark_inc;
  logic               last_word;
  logic               take_a;
  logic               take_b;
  logic               rsp_load;
  bfscs_pkg::scan_t   sc;

  assign req_stall = (state != IDLE);
  assign req_acc   = req_valid && !req_stall;
  assign is_clear  = (req.req_type == bfscs_pkg::REQ_CLEAR);
  assign is_down   = (cur.req_type == bfscs_pkg::REQ_PREV);
  assign is_search = (cur.req_type == bfscs_pkg::REQ_NEXT) ||
                     (cur.req_type == bfscs_pkg::REQ_PREV);

  assign rd_en   = (req_acc && !is_clear) || ((state == SCAN) && (iss < CW'(WT)));
  assign rd_addr = (state == IDLE) ? '0 : iss[AW-1:0];

  // A word that was never written since reset or the last clear reads as zero.
  assign eff_word = rd_valid ? rd_data : '0;

  bfscs_ram #(
    .WIDTH (W),
    .DEPTH (WT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (marked),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bfscs_word_scan u_scan (
    .word    (eff_word),
    .base_id (base_id),
    .item_id (cur.item_id),
    .down    (is_down),
    .res     (sc),
    .marked  (marked)
  );

  assign mark_inc  = (state == SCAN) && rd_pending &&
                     (cur.req_type == bfscs_pkg::REQ_MARK) && sc.sel_in && !sc.sel_hit;
  assign wr_en     = mark_inc;
  assign wr_addr   = proc_idx;
  assign last_word = (proc_idx == AW'(WT - 1));
  assign rsp_load  = (state == FINISH) && (!rsp_valid || !rsp_stall);

  // Words are visited in ascending order: an upward search keeps its first
  // hit, a downward search keeps its latest one.
  assign take_a = sc.hit_a && (is_down || !have_a);
  assign take_b = sc.hit_b && (is_down || !have_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      rsp_valid  <= 1'b0;
      set_count  <= '0;
      word_valid <= '0;
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= rd_en;
      rd_valid   <= word_valid[rd_addr];
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (wr_en) begin
        word_valid[wr_addr] <= 1'b1;
      end
      unique case (state)
        IDLE: begin
          if (req_acc) begin
            cur      <= req;
            iss      <= CW'(1);
            proc_idx <= '0;
            base_id  <= IW'(1);
            have_a   <= 1'b0;
            have_b   <= 1'b0;
            hit_any  <= 1'b0;
            if (is_clear) begin
              word_valid <= '0;
              set_count  <= '0;
              state      <= FINISH;
            end else begin
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (iss < CW'(WT)) begin
            iss <= iss + CW'(1);
          end
          if (rd_pending) begin
            if (take_a) begin
              have_a <= 1'b1;
              id_a   <= sc.id_a;
            end
            if (take_b) begin
              have_b <= 1'b1;
              id_b   <= sc.id_b;
            end
            hit_any   <= hit_any | sc.sel_hit;
            set_count <= set_count + IW'(mark_inc);
            base_id   <= base_id + IW'(W);
            proc_idx  <= proc_idx + AW'(1);
            if (last_word) begin
              state <= FINISH;
            end
          end
        end
        FINISH: begin
          if (rsp_load) begin
            rsp.is_set    <= (cur.req_type == bfscs_pkg::REQ_TEST) && hit_any;
            rsp.found_id  <= !is_search ? '0 : (have_a ? id_a : (have_b ? id_b : '0));
            rsp.total_set <= set_count;
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // The count moves only through a mark of a clear flag or a clear request.
  a_count_source: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (set_count != $past(set_count))) |->
      ($past(mark_inc) || $past(req_acc && is_clear)))
    else $error("set_count changed without a mark or clear");

  // A write-back never collides with a read of the same word.
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("RAM read and write to the same word in one cycle");

  // A new response appears only from FINISH, after a walk or a clear request.
  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == FINISH))
    else $error("response raised outside FINISH");

endmodule

`default_nettype wire
